// ===== design/linear_recurrence_term_mod_prime_defines.svh =====
// Assertion macros shared by the linear recurrence block.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef LINEAR_RECURRENCE_TERM_MOD_PRIME_DEFINES_SVH
`define LINEAR_RECURRENCE_TERM_MOD_PRIME_DEFINES_SVH

// same-cycle implication
`define LRT_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define LRT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== design/lrt_pkg.sv =====
// Shared constants, cell control struct and modular add for the recurrence block.
// No dependencies.
package lrt_pkg;

    localparam int WORD_W       = 30;
    localparam int MAX_ORDER_DEF = 16;
    localparam int INDEX_W      = 63;
    localparam int ORDER_W      = 5;
    localparam logic [WORD_W+1:0] PRIME_WIDE = 32'd1000000007;
    localparam logic [WORD_W+1:0] PRIME_X2   = 32'd2000000014;

    typedef struct packed {
        logic              init;
        logic              m_one;
        logic              acc_clr;
        logic              prod_step;
        logic              prod_first;
        logic              a_bit;
        logic              acc_step;
        logic [WORD_W-1:0] t;
        logic              wr_r;
        logic              wr_p;
    } lrt_cell_ctrl_t;

    function automatic logic [WORD_W-1:0] mod_add3(input logic [WORD_W-1:0] a,
                                                   input logic [WORD_W-1:0] b,
                                                   input logic [WORD_W-1:0] c);
        logic [WORD_W+1:0] s;
        s = {2'b00, a} + {2'b00, b} + {2'b00, c};
        if (s >= PRIME_X2)
            s = s - PRIME_X2;
        else if (s >= PRIME_WIDE)
            s = s - PRIME_WIDE;
        return s[WORD_W-1:0];
    endfunction

endpackage

// ===== design/lrt_cell.sv =====
// One coefficient cell: result, power, accumulator and partial product words.
// Depends on lrt_pkg.
module lrt_cell #(
    parameter int IDX = 0
) (
    input  logic                        clk,
    input  lrt_pkg::lrt_cell_ctrl_t     ctrl,
    input  logic                        active,
    input  logic [lrt_pkg::WORD_W-1:0]  acc_in,
    output logic [lrt_pkg::WORD_W-1:0]  acc,
    output logic [lrt_pkg::WORD_W-1:0]  r,
    output logic [lrt_pkg::WORD_W-1:0]  p
);
    import lrt_pkg::*;

    logic [WORD_W-1:0] r_reg, r_next;
    logic [WORD_W-1:0] p_reg, p_next;
    logic [WORD_W-1:0] acc_reg, acc_next;
    logic [WORD_W-1:0] prod_reg, prod_next;
    logic [WORD_W-1:0] dbl;

    always_comb
    begin
        r_next    = r_reg;
        p_next    = p_reg;
        acc_next  = acc_reg;
        prod_next = prod_reg;
        dbl       = ctrl.prod_first ? '0 : prod_reg;
        if (ctrl.init)
        begin
            r_next = (IDX == 0) ? WORD_W'(1) : '0;
            if (IDX == 0)
                p_next = ctrl.m_one ? WORD_W'(1) : '0;
            else if (IDX == 1)
                p_next = ctrl.m_one ? '0 : WORD_W'(1);
            else
                p_next = '0;
        end
        if (ctrl.acc_clr)
            acc_next = '0;
        if (ctrl.acc_step)
            acc_next = active ? mod_add3(acc_in, ctrl.t, prod_reg) : '0;
        if (ctrl.prod_step)
            prod_next = mod_add3(dbl, dbl, ctrl.a_bit ? p_reg : '0);
        if (ctrl.wr_r)
            r_next = acc_reg;
        if (ctrl.wr_p)
            p_next = acc_reg;
    end

    always_ff @(posedge clk)
    begin
        r_reg    <= r_next;
        p_reg    <= p_next;
        acc_reg  <= acc_next;
        prod_reg <= prod_next;
    end

    assign acc = acc_reg;
    assign r   = r_reg;
    assign p   = p_reg;

endmodule

// ===== design/linear_recurrence_term_mod_prime.sv =====
// Top level of the linear recurrence term block: control sequencer and cell row.
// Depends on lrt_pkg, lrt_cell and linear_recurrence_term_mod_prime_defines.svh.
//
// Returns term N-1 of a(k+M) = a(k)+...+a(k+M-1), a(i) = 2^i for i < M, modulo
// 1000000007, where M is the order register (0 reads as 1, above MAX_ORDER as
// MAX_ORDER) and N the term index (0 reads as 1). One item at a time: s_tready is
// high only while the sequencer is idle. Each polynomial product runs Horner over
// the coefficients from the top; each coefficient runs bit-serial double-and-add
// steps over its 30 bits in the cell row, then a shift-and-reduce step. An index
// needs one product per set bit of N-1 and one squaring per bit below its top bit,
// then a final pass weighs the result by powers of two. The result waits in an
// output register.
module linear_recurrence_term_mod_prime #(
    parameter int MAX_ORDER = lrt_pkg::MAX_ORDER_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          order_we,
    input  logic [lrt_pkg::ORDER_W-1:0]   order_wdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [63:0]                   s_tdata,   // [62:0] term_index
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [31:0]                   m_tdata    // [29:0] term_value
);
    import lrt_pkg::*;

    localparam int MW = $clog2(MAX_ORDER + 1);
    localparam int IW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
    localparam int CW = (MW > ORDER_W) ? MW : ORDER_W;
    localparam logic [4:0] BIT_TOP = 5'(WORD_W - 1);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_CHECK = 8'b0000_0010,
        S_CLR   = 8'b0000_0100,
        S_PROD  = 8'b0000_1000,
        S_ACC   = 8'b0001_0000,
        S_WB    = 8'b0010_0000,
        S_EVAL  = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } state_t;

    state_t              state_reg, state_next;
    logic [ORDER_W-1:0]  order_reg, order_next;
    logic [MW-1:0]       m_reg, m_next, m_eff;
    logic [INDEX_W-1:0]  e_reg, e_next;
    logic                a_done_reg, a_done_next;
    logic                a_sel_reg, a_sel_next;
    logic [IW-1:0]       coef_reg, coef_next;
    logic [4:0]          bit_reg, bit_next;
    logic [WORD_W-1:0]   ev_reg, ev_next;
    logic                out_valid_reg, out_valid_next;
    logic [WORD_W-1:0]   out_reg, out_next;

    logic [CW-1:0]       order_ext;
    logic [MW-1:0]       m_dec;
    logic [IW-1:0]       m_top;
    logic [INDEX_W-1:0]  n_in;
    logic [WORD_W-1:0]   acc_arr [MAX_ORDER];
    logic [WORD_W-1:0]   r_arr   [MAX_ORDER];
    logic [WORD_W-1:0]   p_arr   [MAX_ORDER];
    logic [WORD_W-1:0]   a_word;
    logic                accept;
    lrt_cell_ctrl_t      ctrl;

    assign order_ext = CW'(order_reg);
    assign m_eff = (order_reg == '0) ? MW'(1) :
                   (order_ext > CW'(MAX_ORDER)) ? MW'(MAX_ORDER) : MW'(order_reg);
    assign m_dec  = m_reg - MW'(1);
    assign m_top  = m_dec[IW-1:0];
    assign n_in   = s_tdata[INDEX_W-1:0];
    assign accept = s_tvalid && s_tready;
    assign a_word = a_sel_reg ? r_arr[coef_reg] : p_arr[coef_reg];

    always_comb
    begin
        state_next     = state_reg;
        order_next     = order_we ? order_wdata : order_reg;
        m_next         = m_reg;
        e_next         = e_reg;
        a_done_next    = a_done_reg;
        a_sel_next     = a_sel_reg;
        coef_next      = coef_reg;
        bit_next       = bit_reg;
        ev_next        = ev_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_next       = out_reg;

        ctrl            = '0;
        ctrl.m_one      = (m_eff == MW'(1));
        ctrl.prod_first = (bit_reg == BIT_TOP);
        ctrl.a_bit      = a_word[bit_reg];
        ctrl.t          = acc_arr[m_top];

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    ctrl.init   = 1'b1;
                    m_next      = m_eff;
                    e_next      = (n_in == '0) ? '0 : n_in - INDEX_W'(1);
                    a_done_next = 1'b0;
                    state_next  = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (e_reg == '0)
                begin
                    ev_next    = '0;
                    coef_next  = m_top;
                    state_next = S_EVAL;
                end
                else if (e_reg[0] && !a_done_reg)
                begin
                    a_done_next = 1'b1;
                    a_sel_next  = 1'b1;
                    state_next  = S_CLR;
                end
                else
                begin
                    e_next      = e_reg >> 1;
                    a_done_next = 1'b0;
                    a_sel_next  = 1'b0;
                    if ((e_reg >> 1) != '0)
                        state_next = S_CLR;
                    else
                    begin
                        ev_next    = '0;
                        coef_next  = m_top;
                        state_next = S_EVAL;
                    end
                end
            end
            S_CLR:
            begin
                ctrl.acc_clr = 1'b1;
                coef_next    = m_top;
                bit_next     = BIT_TOP;
                state_next   = S_PROD;
            end
            S_PROD:
            begin
                ctrl.prod_step = 1'b1;
                if (bit_reg == '0)
                    state_next = S_ACC;
                else
                    bit_next = bit_reg - 5'd1;
            end
            S_ACC:
            begin
                ctrl.acc_step = 1'b1;
                bit_next      = BIT_TOP;
                if (coef_reg == '0)
                    state_next = S_WB;
                else
                begin
                    coef_next  = coef_reg - IW'(1);
                    state_next = S_PROD;
                end
            end
            S_WB:
            begin
                ctrl.wr_r  = a_sel_reg;
                ctrl.wr_p  = !a_sel_reg;
                state_next = S_CHECK;
            end
            S_EVAL:
            begin
                ev_next = mod_add3(ev_reg, ev_reg, r_arr[coef_reg]);
                if (coef_reg == '0)
                    state_next = S_DONE;
                else
                    coef_next = coef_reg - IW'(1);
            end
            S_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_next       = ev_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            order_reg     <= ORDER_W'(2);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            order_reg     <= order_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg      <= m_next;
        e_reg      <= e_next;
        a_done_reg <= a_done_next;
        a_sel_reg  <= a_sel_next;
        coef_reg   <= coef_next;
        bit_reg    <= bit_next;
        ev_reg     <= ev_next;
        out_reg    <= out_next;
    end

    genvar g;
    generate
        for (g = 0; g < MAX_ORDER; g++)
        begin : g_cell
            logic [WORD_W-1:0] acc_left;
            if (g == 0)
            begin : g_first
                assign acc_left = '0;
            end
            else
            begin : g_rest
                assign acc_left = acc_arr[g-1];
            end
            lrt_cell #(.IDX(g)) u_cell (
                .clk    (clk),
                .ctrl   (ctrl),
                .active (MW'(g) < m_reg),
                .acc_in (acc_left),
                .acc    (acc_arr[g]),
                .r      (r_arr[g]),
                .p      (p_arr[g])
            );
        end
    endgenerate

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_reg};

`include "linear_recurrence_term_mod_prime_defines.svh"

    `LRT_ASSERT_NEXT(a_busy_after_take, accept, !s_tready)
    `LRT_ASSERT_SAME(a_value_reduced, m_tvalid, {2'b00, m_tdata[WORD_W-1:0]} < PRIME_WIDE)
    `LRT_ASSERT_SAME(a_coef_in_range, state_reg == S_PROD, MW'(coef_reg) < m_reg)
    `LRT_ASSERT_SAME(a_order_clamped, 1'b1, m_eff != '0 && m_eff <= MW'(MAX_ORDER))

endmodule
